@@ sv/sorted_index_set_assert.svh @@
// assertion macros for the sorted index set
`ifndef SORTED_INDEX_SET_ASSERT_SVH
`define SORTED_INDEX_SET_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SIS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define SIS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define SIS_ASSERT(label, prop, msg)

`define SIS_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ sv/sis_pkg.sv @@
// types and constants shared by the sorted index set modules
`timescale 1ns / 1ps
`default_nettype none

package sis_pkg;

   localparam int SET_CAPACITY       = 64;
   localparam int INDEX_WIDTH        = 16;
   localparam int COUNT_WIDTH        = $clog2(SET_CAPACITY + 1);
   localparam int SEQ_WIDTH          = 16;
   localparam int FIELD_INDEX_WIDTH  = 16;
   localparam int ENTRY_TOTAL_WIDTH  = 7;
   localparam int CMP_WIDTH          = 33;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_RANGE     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   localparam logic [2:0] CLASS_INVALID  = 3'd0;
   localparam logic [2:0] CLASS_EXPLICIT = 3'd1;
   localparam logic [2:0] CLASS_FIRST    = 3'd2;
   localparam logic [2:0] CLASS_SECOND   = 3'd3;
   localparam logic [2:0] CLASS_LAST     = 3'd4;
   localparam logic [2:0] CLASS_INTERIOR = 3'd5;

   typedef struct packed {
      logic                         op;
      logic [FIELD_INDEX_WIDTH-1:0] position_index;
   } req_item_type;

   typedef struct packed {
      logic [1:0]                   status;
      logic                         found;
      logic [2:0]                   position_class;
      logic [ENTRY_TOTAL_WIDTH-1:0] entry_total;
   } rsp_item_type;

   typedef struct packed {
      logic                   occ;
      logic                   lt;
      logic [INDEX_WIDTH-1:0] value;
   } cell_link_type;

endpackage

`default_nettype wire

@@ sv/sis_cell.sv @@
// one slot of the sorted chain: compares against the item and shifts on insert
`timescale 1ns / 1ps
`default_nettype none

module sis_cell
   import sis_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [INDEX_WIDTH-1:0] idx,
   input  wire logic                   shift_en,
   input  wire cell_link_type          left,
   output cell_link_type               right,
   output logic                        eq
);

   logic                   occ_ff;
   logic                   occ_in;
   logic [INDEX_WIDTH-1:0] value_ff;
   logic [INDEX_WIDTH-1:0] value_in;
   logic                   lt;

   always_comb begin
      lt       = occ_ff && (value_ff < idx);
      eq       = occ_ff && (value_ff == idx);
      occ_in   = occ_ff;
      value_in = value_ff;
      if (!lt) begin
         occ_in   = occ_ff | left.occ;
         value_in = left.lt ? idx : left.value;
      end
      right.occ   = occ_ff;
      right.lt    = lt;
      right.value = value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else if (shift_en) begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         value_ff <= value_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/sorted_index_set.sv @@
// top level of the sorted index set: item control, result register and cell chain
//
//   channel | direction | ports                              | payload
//   req     | in        | req_valid, req_ready, req_item     | op, position_index
//   rsp     | out       | rsp_valid, rsp_ready, rsp_item     | status, found, class, total
//   csr     | in        | csr_valid, csr_ready, csr_data     | sequence_length
//
// an item is registered first; then all cells compare and shift together once the result
// register is free; the next item is taken in the cycle after the result is registered
// the result register lets a new item in while the last result waits
// a stalled result holds back only the evaluation cycle of the following item
// a csr write waits for the item under evaluation and holds off new items
// reset empties the set and clears sequence_length, no clearing pass

`timescale 1ns / 1ps
`default_nettype none

`include "sorted_index_set_assert.svh"

module sorted_index_set
   import sis_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_item_type         req_item,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_item_type              rsp_item,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [SEQ_WIDTH-1:0] csr_data
);

   logic                   busy_ff;
   logic                   busy_in;
   req_item_type           item_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic [SEQ_WIDTH-1:0]   seq_len_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_item_type           rsp_item_ff;
   rsp_item_type           rsp_item_in;

   logic [INDEX_WIDTH-1:0]  idx;
   logic [SET_CAPACITY-1:0] eq_vec;
   cell_link_type           link [0:SET_CAPACITY];
   logic                    commit;
   logic                    shift_en;
   logic                    found;
   logic                    full;
   logic                    in_range;

   assign req_ready = !busy_ff && !csr_valid;
   assign csr_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   assign idx      = INDEX_WIDTH'(item_ff.position_index);
   assign found    = |eq_vec;
   assign full     = link[SET_CAPACITY].occ;
   assign in_range = CMP_WIDTH'(idx) < CMP_WIDTH'(seq_len_ff);
   assign commit   = busy_ff && (!rsp_valid_ff || rsp_ready);
   assign shift_en = commit && (item_ff.op == OP_INSERT) && in_range && !found && !full;

   assign link[0] = '{occ: 1'b1, lt: 1'b1, value: '0};

   for (genvar k = 0; k < SET_CAPACITY; k++) begin : g_cell
      sis_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .idx      (idx),
         .shift_en (shift_en),
         .left     (link[k]),
         .right    (link[k+1]),
         .eq       (eq_vec[k])
      );
   end

   always_comb begin
      count_in = shift_en ? count_ff + COUNT_WIDTH'(1) : count_ff;

      rsp_item_in.status         = STATUS_OK;
      rsp_item_in.found          = found;
      rsp_item_in.position_class = CLASS_INVALID;
      if (item_ff.op == OP_INSERT) begin
         if (!in_range) begin
            rsp_item_in.status = STATUS_RANGE;
            rsp_item_in.found  = 1'b0;
         end else if (!found && full) begin
            rsp_item_in.status = STATUS_FULL;
         end
      end else begin
         if (!in_range) begin
            rsp_item_in.status = STATUS_RANGE;
         end else if (found) begin
            rsp_item_in.position_class = CLASS_EXPLICIT;
         end else if (idx == '0) begin
            rsp_item_in.position_class = CLASS_FIRST;
         end else if (CMP_WIDTH'(idx) == CMP_WIDTH'(1)) begin
            rsp_item_in.position_class = CLASS_SECOND;
         end else if (CMP_WIDTH'(idx) == CMP_WIDTH'(seq_len_ff) - CMP_WIDTH'(1)) begin
            rsp_item_in.position_class = CLASS_LAST;
         end else begin
            rsp_item_in.position_class = CLASS_INTERIOR;
         end
      end
      rsp_item_in.entry_total = ENTRY_TOTAL_WIDTH'(count_in);

      busy_in = busy_ff;
      if (req_valid && req_ready) begin
         busy_in = 1'b1;
      end else if (commit) begin
         busy_in = 1'b0;
      end

      rsp_valid_in = commit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         seq_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            seq_len_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
      if (commit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   `SIS_ASSERT_ALWAYS(a_count_bound, reset || count_ff <= COUNT_WIDTH'(SET_CAPACITY), "count high")
   `SIS_ASSERT(a_full_matches_count, full == (count_ff == COUNT_WIDTH'(SET_CAPACITY)), "full flag")
   `SIS_ASSERT(a_single_match, busy_ff |-> $onehot0(eq_vec), "index matched in more than one cell")
   `SIS_ASSERT(a_insert_counts, shift_en |=> count_ff == $past(count_ff) + COUNT_WIDTH'(1), "count")
   `SIS_ASSERT(a_no_commit_idle, commit |-> busy_ff && !full || !shift_en, "shift while full")

endmodule

`default_nettype wire
